// File: rtl/rt_pkg.sv
// Shared types and constants for the range top-two sum tree.
// Command and status structs joining controller and datapath.
`timescale 1ns / 1ps

package rt_pkg;

	localparam int CFG_W          = 11;
	localparam int POS_W          = 11;
	localparam int IN_VAL_W       = 32;
	localparam int DEF_MAX        = 1024;
	localparam int DEF_VALUE_BITS = 32;

	localparam logic [CFG_W-1:0] COUNT_RESET = 11'd1024;

	localparam logic CMD_SET   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic load;
		logic clear_wr;
		logic leaf_wr;
		logic sib_rd;
		logic parent_wr;
		logic q_left;
		logic q_right;
		logic out_wr;
	} rt_cmd_t;

	typedef struct packed {
		logic set_ok;
		logic query_ok;
		logic clear_last;
		logic at_top;
		logic range_done;
	} rt_stat_t;

endpackage

// File: rtl/rt_ctrl.sv
// Controller for the range top-two sum tree.
// Sequences clearing, set walks and query walks; depends on rt_pkg.
`timescale 1ns / 1ps

module rt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              command,
	input  rt_pkg::rt_stat_t  stat,
	output rt_pkg::rt_cmd_t   cmd,
	output logic              busy,
	output logic              done
);
	import rt_pkg::*;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_LEAF  = 8'b0000_0100,
		ST_SRD   = 8'b0000_1000,
		ST_SMG   = 8'b0001_0000,
		ST_QL    = 8'b0010_0000,
		ST_QR    = 8'b0100_0000,
		ST_QOUT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (command == CMD_SET) begin
						state_d = stat.set_ok ? ST_LEAF : ST_IDLE;
					end else begin
						state_d = stat.query_ok ? ST_QL : ST_QOUT;
					end
				end
			end
			ST_LEAF: begin
				cmd.leaf_wr = 1'b1;
				state_d     = ST_SRD;
			end
			ST_SRD: begin
				cmd.sib_rd = 1'b1;
				state_d    = ST_SMG;
			end
			ST_SMG: begin
				cmd.parent_wr = 1'b1;
				state_d       = stat.at_top ? ST_IDLE : ST_SRD;
			end
			ST_QL: begin
				if (stat.range_done) begin
					state_d = ST_QOUT;
				end else begin
					cmd.q_left = 1'b1;
					state_d    = ST_QR;
				end
			end
			ST_QR: begin
				cmd.q_right = 1'b1;
				state_d     = ST_QL;
			end
			ST_QOUT: begin
				cmd.out_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.out_wr;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// File: rtl/rt_dp.sv
// Datapath for the range top-two sum tree: node memory, cursors, pair merge.
// Holds the element count register; depends on rt_pkg.
`timescale 1ns / 1ps

module rt_dp #(
	parameter int MAX_ELEMENTS = rt_pkg::DEF_MAX,
	parameter int VALUE_BITS   = rt_pkg::DEF_VALUE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rt_pkg::rt_cmd_t             cmd,
	output rt_pkg::rt_stat_t            stat,
	input  logic                        cfg_valid,
	input  logic [rt_pkg::CFG_W-1:0]    element_count,
	input  logic [rt_pkg::POS_W-1:0]    position,
	input  logic [rt_pkg::IN_VAL_W-1:0] new_value,
	input  logic [rt_pkg::POS_W-1:0]    range_low,
	input  logic [rt_pkg::POS_W-1:0]    range_high,
	output logic [VALUE_BITS:0]         pair_sum
);
	import rt_pkg::*;

	localparam int NODE_COUNT = 2 * MAX_ELEMENTS;
	localparam int IDX_W      = $clog2(NODE_COUNT);
	localparam int CUR_W      = $clog2(NODE_COUNT + 1);
	localparam int LIM_W      = ((CUR_W > CFG_W) ? CUR_W : CFG_W) + 1;
	localparam int VW         = VALUE_BITS;

	logic [CFG_W-1:0]      count_q;
	logic [2*VW-1:0]       mem [NODE_COUNT];
	logic [2*VW-1:0]       rdata_q;
	logic [IDX_W-1:0]      clr_q;
	logic [IDX_W-1:0]      cur_q;
	logic [CUR_W-1:0]      l_q;
	logic [CUR_W-1:0]      r_q;
	logic [VW-1:0]         val_q;
	logic [VW-1:0]         acc_top_q;
	logic [VW-1:0]         acc_next_q;
	logic                  rd_pend_q;
	logic [VW:0]           pair_sum_q;

	logic [LIM_W-1:0]      cnt_ext, max_ext, n, pos_ext, lo_c, hi_ext, hi_c;
	logic [LIM_W-1:0]      leaf_w, l_w, r_w;
	logic [VW+IN_VAL_W-1:0] val_ext;
	logic [CUR_W-1:0]      r_dec;
	logic                  we, re;
	logic [IDX_W-1:0]      waddr, raddr;
	logic [2*VW-1:0]       wdata;
	logic [VW-1:0]         b_top, b_next, m_top, m_low, m_next;

	// clip the request against the live element count
	always_comb begin
		cnt_ext = LIM_W'(count_q);
		max_ext = LIM_W'(MAX_ELEMENTS);
		n       = (cnt_ext > max_ext) ? max_ext : cnt_ext;
		pos_ext = LIM_W'(position);
		hi_ext  = LIM_W'(range_high);
		lo_c    = (range_low == '0) ? LIM_W'(1) : LIM_W'(range_low);
		hi_c    = (hi_ext > n) ? n : hi_ext;
		leaf_w  = pos_ext - LIM_W'(1) + max_ext;
		l_w     = lo_c - LIM_W'(1) + max_ext;
		r_w     = hi_c + max_ext;
		val_ext = {{VW{1'b0}}, new_value};
	end

	assign stat.set_ok     = (pos_ext != '0) && (pos_ext <= n);
	assign stat.query_ok   = (lo_c <= hi_c);
	assign stat.clear_last = (clr_q == IDX_W'(NODE_COUNT - 1));
	assign stat.at_top     = (cur_q[IDX_W-1:1] == (IDX_W-1)'(1));
	assign stat.range_done = (l_q >= r_q);

	// merge the accumulated pair with the node just read
	always_comb begin
		b_top  = rdata_q[2*VW-1:VW];
		b_next = rdata_q[VW-1:0];
		if (acc_top_q < b_top) begin
			m_top = b_top;
			m_low = acc_top_q;
		end else begin
			m_top = acc_top_q;
			m_low = b_top;
		end
		m_next = m_low;
		if (acc_next_q > m_next) m_next = acc_next_q;
		if (b_next > m_next) m_next = b_next;
	end

	assign r_dec = r_q - CUR_W'(1);

	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = {m_top, m_next};
		if (cmd.clear_wr) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (cmd.leaf_wr) begin
			we    = 1'b1;
			wdata = {val_q, {VW{1'b0}}};
		end else if (cmd.parent_wr) begin
			we    = 1'b1;
			waddr = {1'b0, cur_q[IDX_W-1:1]};
		end
		re    = 1'b0;
		raddr = cur_q ^ IDX_W'(1);
		if (cmd.sib_rd) begin
			re = 1'b1;
		end else if (cmd.q_left) begin
			re    = l_q[0];
			raddr = l_q[IDX_W-1:0];
		end else if (cmd.q_right) begin
			re    = r_q[0];
			raddr = r_dec[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= COUNT_RESET;
			clr_q     <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (cfg_valid) count_q <= element_count;
			if (cmd.clear_wr) clr_q <= clr_q + IDX_W'(1);
			rd_pend_q <= (cmd.q_left && l_q[0]) || (cmd.q_right && r_q[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q      <= leaf_w[IDX_W-1:0];
			l_q        <= l_w[CUR_W-1:0];
			r_q        <= r_w[CUR_W-1:0];
			val_q      <= val_ext[VW-1:0];
			acc_top_q  <= '0;
			acc_next_q <= '0;
		end else begin
			if (cmd.leaf_wr) begin
				acc_top_q  <= val_q;
				acc_next_q <= '0;
			end else if (cmd.parent_wr || rd_pend_q) begin
				acc_top_q  <= m_top;
				acc_next_q <= m_next;
			end
			if (cmd.parent_wr) cur_q <= {1'b0, cur_q[IDX_W-1:1]};
			if (cmd.q_left && l_q[0]) l_q <= l_q + CUR_W'(1);
			if (cmd.q_right) begin
				l_q <= {1'b0, l_q[CUR_W-1:1]};
				r_q <= {1'b0, r_q[CUR_W-1:1]};
			end
		end
		if (cmd.out_wr) pair_sum_q <= {1'b0, acc_top_q} + {1'b0, acc_next_q};
	end

	assign pair_sum = pair_sum_q;

endmodule

// File: rtl/range_top_two_sum_tree.sv
// Top level of the range top-two sum tree.
// Instantiates rt_ctrl and rt_dp; depends on rt_pkg.
`timescale 1ns / 1ps

// Usage: after reset the block clears its 2*MAX_ELEMENTS-node memory, one node
// a cycle, with busy high; element_count writes are taken at any time. Issue
// an item by raising start while busy is low. A set writes the leaf and walks
// to the root, a sibling read then a parent write per level, since each level
// needs one read of the sibling through the single read port. An ignored set
// leaves the block idle. A query walks up to log2(2*MAX_ELEMENTS) levels with
// up to two node reads per level. The result appears on pair_sum with done
// high for exactly one cycle; it cannot be stalled, so capture it then.
module range_top_two_sum_tree #(
	parameter int MAX_ELEMENTS = rt_pkg::DEF_MAX,
	parameter int VALUE_BITS   = rt_pkg::DEF_VALUE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [0:0]                  command,
	input  logic [rt_pkg::POS_W-1:0]    position,
	input  logic [rt_pkg::IN_VAL_W-1:0] new_value,
	input  logic [rt_pkg::POS_W-1:0]    range_low,
	input  logic [rt_pkg::POS_W-1:0]    range_high,
	output logic                        done,
	output logic [VALUE_BITS:0]         pair_sum,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rt_pkg::CFG_W-1:0]    element_count
);
	import rt_pkg::*;

	rt_cmd_t  cmd;
	rt_stat_t stat;

	assign cfg_ready = 1'b1;

	rt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command[0]),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	rt_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.VALUE_BITS   (VALUE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_valid     (cfg_valid & cfg_ready),
		.element_count (element_count),
		.position      (position),
		.new_value     (new_value),
		.range_low     (range_low),
		.range_high    (range_high),
		.pair_sum      (pair_sum)
	);

endmodule

// File: sim/tb_range_top_two_sum_tree.sv
// Testbench for range_top_two_sum_tree: random and directed set/query items checked
// against a behavioral top-two segment tree kept inside the bench.
// Depends on rt_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_range_top_two_sum_tree;
	import rt_pkg::*;

	localparam int LEAVES      = DEF_MAX;
	localparam int SETTLE      = 40;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [DEF_VALUE_BITS-1:0] top;
		logic [DEF_VALUE_BITS-1:0] nxt;
	} pair_t;

	typedef struct {
		logic [0:0]          command;
		logic [POS_W-1:0]    position;
		logic [IN_VAL_W-1:0] new_value;
		logic [POS_W-1:0]    range_low;
		logic [POS_W-1:0]    range_high;
	} tree_item_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [0:0]              command = CMD_SET;
	logic [POS_W-1:0]        position = '0;
	logic [IN_VAL_W-1:0]     new_value = '0;
	logic [POS_W-1:0]        range_low = '0;
	logic [POS_W-1:0]        range_high = '0;
	logic                    done;
	logic [DEF_VALUE_BITS:0] pair_sum;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_W-1:0]        element_count = COUNT_RESET;

	pair_t                   tree_node [2*LEAVES];
	logic [CFG_W-1:0]        count_reg = COUNT_RESET;
	tree_item_t              pending_q [$];
	tree_item_t              cur_item;
	logic [DEF_VALUE_BITS:0] pair_sum_expect_q [$];
	logic [DEF_VALUE_BITS:0] sum_want;
	logic [CFG_W-1:0]        phase_count [8] = '{11'd1024, 11'd1, 11'd2047, 11'd5,
		11'd0, 11'd700, 11'd1024, 11'd0};
	logic                    no_gap = 1'b0;
	int                      items_pushed = 0;
	int                      items_taken = 0;
	int                      set_count = 0;
	int                      query_count = 0;
	int                      sums_checked = 0;
	int                      count_settings = 0;
	int                      errors = 0;
	int                      cycle_count = 0;

	range_top_two_sum_tree dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.position     (position),
		.new_value    (new_value),
		.range_low    (range_low),
		.range_high   (range_high),
		.done         (done),
		.pair_sum     (pair_sum),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.element_count(element_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < 2*LEAVES; i++) begin
			tree_node[i] = '0;
		end
	end

	function automatic pair_t merge_top_two(input pair_t a, input pair_t b);
		pair_t m;
		if (a.top < b.top) begin
			m.top = b.top;
			m.nxt = a.top;
		end else begin
			m.top = a.top;
			m.nxt = b.top;
		end
		if (a.nxt > m.nxt) m.nxt = a.nxt;
		if (b.nxt > m.nxt) m.nxt = b.nxt;
		return m;
	endfunction

	function automatic void tree_apply(input tree_item_t it);
		int unsigned live, idx, l, r, lo, hi;
		pair_t acc;
		logic [DEF_VALUE_BITS:0] sum_calc;
		live = (count_reg > LEAVES) ? LEAVES : count_reg;
		if (it.command == CMD_SET) begin
			set_count++;
			if (it.position != 0 && it.position <= live) begin
				idx = it.position - 1 + LEAVES;
				tree_node[idx].top = it.new_value;
				tree_node[idx].nxt = '0;
				idx = idx >> 1;
				while (idx >= 1) begin
					tree_node[idx] = merge_top_two(tree_node[2*idx], tree_node[2*idx+1]);
					idx = idx >> 1;
				end
			end
		end else begin
			query_count++;
			acc = '0;
			lo = (it.range_low < 1) ? 1 : it.range_low;
			hi = (it.range_high > live) ? live : it.range_high;
			if (lo <= hi) begin
				l = lo - 1 + LEAVES;
				r = hi + LEAVES;
				while (l < r) begin
					if (l[0]) begin
						acc = merge_top_two(acc, tree_node[l]);
						l++;
					end
					if (r[0]) begin
						r--;
						acc = merge_top_two(acc, tree_node[r]);
					end
					l = l >> 1;
					r = r >> 1;
				end
			end
			sum_calc = {1'b0, acc.top} + {1'b0, acc.nxt};
			pair_sum_expect_q = {pair_sum_expect_q, sum_calc};
		end
	endfunction

	function automatic tree_item_t item_of(input logic [0:0] cmd, input int unsigned pos,
		input logic [IN_VAL_W-1:0] val, input int unsigned lo, input int unsigned hi);
		tree_item_t it;
		it.command    = cmd;
		it.position   = POS_W'(pos);
		it.new_value  = val;
		it.range_low  = POS_W'(lo);
		it.range_high = POS_W'(hi);
		return it;
	endfunction

	function automatic tree_item_t make_item(input logic [CFG_W-1:0] cnt);
		tree_item_t it;
		int unsigned live, pick, a, b;
		live = (cnt > LEAVES) ? LEAVES : cnt;
		it.command = ($urandom_range(99, 0) < 55) ? CMD_SET : CMD_QUERY;
		pick = $urandom_range(99, 0);
		if (pick < 85 && live > 0) it.position = POS_W'($urandom_range(live, 1));
		else if (pick < 92) it.position = ($urandom_range(1, 0) == 0) ? '0 : POS_W'(live + 1);
		else it.position = POS_W'($urandom_range(2047, 0));
		pick = $urandom_range(99, 0);
		if (pick < 40) it.new_value = $urandom;
		else if (pick < 70) it.new_value = $urandom_range(15, 0);
		else if (pick < 80) it.new_value = '1;
		else if (pick < 88) it.new_value = '0;
		else it.new_value = $urandom >> $urandom_range(31, 0);
		pick = $urandom_range(99, 0);
		if (pick < 70 && live > 0) begin
			a = $urandom_range(live, 1);
			if ($urandom_range(1, 0) == 0) b = a + $urandom_range(8, 0);
			else b = $urandom_range(live, 1);
			if (b > live) b = live;
			if (a > b) {a, b} = {b, a};
		end else if (pick < 80) begin
			a = 0;
			b = $urandom_range(2047, 0);
		end else if (pick < 88) begin
			a = $urandom_range(2047, 1);
			b = $urandom_range(a - 1, 0);
		end else begin
			a = $urandom_range(2047, 0);
			b = $urandom_range(2047, 0);
		end
		it.range_low  = POS_W'(a);
		it.range_high = POS_W'(b);
		return it;
	endfunction

	task automatic queue_item(input tree_item_t it);
		pending_q = {pending_q, it};
		items_pushed++;
	endtask

	task automatic wait_results();
		while (items_taken != items_pushed || pair_sum_expect_q.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		wait_results();
		repeat (SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_count(input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		element_count <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		count_settings++;
	endtask

	// driver
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) count_reg = element_count;
		if (start && !busy) begin
			tree_apply(cur_item);
			items_taken++;
		end
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && busy) begin
			// hold the item until taken
		end else if (pending_q.size() == 0 || (!no_gap && $urandom_range(99, 0) < 12)) begin
			start <= 1'b0;
		end else begin
			cur_item = pending_q.pop_front();
			start <= 1'b1;
			command <= cur_item.command;
			position <= cur_item.position;
			new_value <= cur_item.new_value;
			range_low <= cur_item.range_low;
			range_high <= cur_item.range_high;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			sums_checked++;
			if (pair_sum_expect_q.size() == 0) begin
				$display("%0t: unexpected pair_sum, expected none, actual %0d", $time, pair_sum);
				errors++;
			end else begin
				sum_want = pair_sum_expect_q.pop_front();
				if (pair_sum !== sum_want) begin
					$display("%0t: pair_sum mismatch, expected %0d, actual %0d",
						$time, sum_want, pair_sum);
					errors++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
		$display("Timeout after %0d cycles, %0d of %0d items taken",
			cycle_count, items_taken, items_pushed);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] cnt;
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		queue_item(item_of(CMD_QUERY, 0, '0, 1, 1024));
		queue_item(item_of(CMD_SET, 1, '1, 0, 0));
		queue_item(item_of(CMD_SET, 1024, '1, 2047, 2047));
		queue_item(item_of(CMD_QUERY, 2047, '1, 0, 2047));
		queue_item(item_of(CMD_QUERY, 0, '0, 1, 1));
		queue_item(item_of(CMD_SET, 0, 32'd5, 0, 0));
		queue_item(item_of(CMD_SET, 1025, 32'd5, 0, 0));
		queue_item(item_of(CMD_SET, 2047, 32'd5, 0, 0));
		queue_item(item_of(CMD_QUERY, 0, '0, 1, 1024));
		queue_item(item_of(CMD_SET, 512, 32'd7, 0, 0));
		queue_item(item_of(CMD_SET, 513, 32'd7, 0, 0));
		queue_item(item_of(CMD_QUERY, 0, '0, 512, 513));
		queue_item(item_of(CMD_QUERY, 0, '0, 513, 512));
		queue_item(item_of(CMD_QUERY, 0, '0, 0, 0));
		queue_item(item_of(CMD_QUERY, 0, '0, 2047, 2047));
		queue_item(item_of(CMD_QUERY, 0, '0, 1025, 2047));
		queue_item(item_of(CMD_SET, 1, '0, 0, 0));
		queue_item(item_of(CMD_QUERY, 0, '0, 1, 600));
		queue_item(item_of(CMD_SET, 700, 32'h8000_0000, 0, 0));
		queue_item(item_of(CMD_QUERY, 0, '0, 2, 1023));
		queue_item(item_of(CMD_QUERY, 0, '0, 1000, 1024));
		settle();
		for (int ph = 0; ph < 8; ph++) begin
			cnt = (ph == 7) ? CFG_W'($urandom_range(1024, 2)) : phase_count[ph];
			write_count(cnt);
			no_gap = (ph == 3);
			n = (cnt == 0) ? 60 : 220;
			for (int chunk = 0; chunk < 4; chunk++) begin
				@(negedge clk);
				repeat (n / 4) queue_item(make_item(cnt));
				// after the second chunk, drop to idle until every pending sum is back
				if (chunk == 1) wait_results();
			end
			settle();
		end
		$display("Run covered %0d sets and %0d queries over %0d element_count settings,",
			set_count, query_count, count_settings);
		$display("with %0d range sums compared in %0d cycles.", sums_checked, cycle_count);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
